// ===== sv/ppd_pkg.sv =====
// ----------------------------------------------------------------------------
// ppd_pkg
// Shared constants for the PID PWM drive unit: register map, reset values and
// the operand widths of the shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package ppd_pkg;

	// Default width of the signed error sample.
	localparam int ERROR_WIDTH_DEF = 16;

	// Configuration port.
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INT_GAIN_DT    = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN_DT  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN        = 8'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX        = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 8'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_WINDOW   = 8'd6;
	localparam logic [CFG_IDX_W-1:0] REG_PWM_TOP        = 8'd7;

	// Reset values of the registers.
	localparam logic [15:0] RST_PROP_GAIN      = 16'd415;
	localparam logic [15:0] RST_INT_GAIN_DT    = 16'd1311;
	localparam logic [15:0] RST_DERIV_GAIN_DT  = 16'd582;
	localparam logic [7:0]  RST_OUT_MIN        = 8'd100;
	localparam logic [7:0]  RST_OUT_MAX        = 8'd255;
	localparam logic [30:0] RST_INTEGRAL_LIMIT = 31'd992;
	localparam logic [14:0] RST_ERROR_WINDOW   = 15'd2304;
	localparam logic [15:0] RST_PWM_TOP        = 16'd255;

	// Drive level used when the error is outside the window.
	localparam logic [15:0] FULL_DRIVE = 16'd255;

	// Shared multiplier: signed A by signed B, product registered.
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 21;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// ceil(2^22 / 5): floor(y * RECIP_FIVE / 2^22) equals floor(y / 5) for y < 2^21.
	localparam logic [19:0] RECIP_FIVE = 20'd838861;
	localparam int          RECIP_SHIFT = 22;

endpackage

`default_nettype wire

// ===== sv/ppd_mul.sv =====
// ----------------------------------------------------------------------------
// ppd_mul
// Shared signed multiplier with a registered product, loaded when enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module ppd_mul
	import ppd_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic signed [MUL_A_W-1:0] a,
	input  wire logic signed [MUL_B_W-1:0] b,
	output logic signed [MUL_P_W-1:0]      p_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= a * b;
		end
	end

endmodule

`default_nettype wire

// ===== sv/pid_pwm_drive_unit.sv =====
// ----------------------------------------------------------------------------
// pid_pwm_drive_unit
// PID motor drive with clamped integral and inverted PWM compare output.
// ----------------------------------------------------------------------------
// Usage:
// One signed Q8.8 error sample enters per control tick on the slave stream
// (s_tvalid/s_tready/s_tdata). Each accepted request yields exactly one result
// on the master stream: m_tdata carries compare_value (low 16 bits) and
// drive_level (high 16 bits); m_tuser carries in_window.
// Gains, output bounds, integral limit, error window and PWM top are written
// through the cfg_valid/cfg_ready channel, which is always ready. Writes are
// meant to happen only while the block is idle; unknown indexes are ignored.
// An in-window sample steps through MNUM, MQ, MAP, MP, CLP, MD, ADDD and
// FIN after acceptance before m_tvalid rises; an out-of-window sample goes
// straight to FIN. All products run through one shared 33 x 21 bit
// multiplier in turn (error scaling, divide-by-twenty reciprocal, proportional,
// integral and derivative terms), so s_tready is low while a sample is being worked.
// If the receiver stalls, the finished result stays in the output register
// and the sequencer waits in its last step until the register frees up.
// Reset (arst_n low) restores the register defaults, clears the stored
// previous mapped error and the integral, and drops m_tvalid.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_pwm_drive_unit
	import ppd_pkg::*;
#(
	parameter int ERROR_WIDTH = ERROR_WIDTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Slave stream; s_tdata fields from bit 0: error_sample.
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [((ERROR_WIDTH+7)/8)*8-1:0]    s_tdata,
	// Master stream; m_tdata fields from bit 0: compare_value, drive_level.
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [31:0]                              m_tdata,
	// m_tuser fields from bit 0: in_window.
	output logic                                     m_tuser,
	// Configuration write channel.
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]                cfg_index,
	input  wire logic [CFG_DATA_W-1:0]               cfg_data
);

	// Width for comparing the error magnitude against the 15-bit window.
	localparam int CMP_W = (ERROR_WIDTH > 15) ? ERROR_WIDTH : 15;
	localparam int ACC_W = 52;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_MNUM = 9'b000000010,
		ST_MQ   = 9'b000000100,
		ST_MAP  = 9'b000001000,
		ST_MP   = 9'b000010000,
		ST_CLP  = 9'b000100000,
		ST_MD   = 9'b001000000,
		ST_ADDD = 9'b010000000,
		ST_FIN  = 9'b100000000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [15:0] prop_gain_q, int_gain_dt_q, deriv_gain_dt_q, pwm_top_q;
	logic [7:0]  out_min_q, out_max_q;
	logic [30:0] integral_limit_q;
	logic [14:0] error_window_q;

	// Loop state.
	logic signed [23:0] prev_q;
	logic signed [31:0] integral_q;

	// Working registers.
	logic [14:0]              mag_q;
	logic                     inwin_q;
	logic                     num_neg_q;
	logic signed [23:0]       mapped_q;
	logic signed [24:0]       deriv_q;
	logic signed [ACC_W-1:0]  acc_q;

	// Shared multiplier.
	logic                      mul_en;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] prod_q;

	ppd_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod_q)
	);

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);

	// Error magnitude and window test at acceptance.
	logic signed [ERROR_WIDTH-1:0] err;
	logic [ERROR_WIDTH-1:0]        mag;
	logic [CMP_W-1:0]              mag_ext;
	logic                          in_win;

	always_comb begin
		err     = $signed(s_tdata[ERROR_WIDTH-1:0]);
		mag     = err[ERROR_WIDTH-1] ? ERROR_WIDTH'(-err) : ERROR_WIDTH'(err);
		mag_ext = CMP_W'(mag);
		in_win  = mag_ext < CMP_W'(error_window_q);
	end

	// Datapath pieces used by individual sequencer steps.
	logic signed [8:0]  diff;
	logic [22:0]        anum;
	logic [23:0]        anum_rnd;
	logic [21:0]        y;
	logic [18:0]        q;
	logic signed [23:0] mapped;
	logic signed [33:0] isum;
	logic signed [33:0] lim;
	logic signed [31:0] isum_c;
	logic signed [40:0] p16;
	logic [23:0]        p16_c;
	logic [ACC_W-1:0]   rnd;
	logic [27:0]        drv_raw;
	logic [15:0]        drive;

	always_comb begin
		diff     = $signed({1'b0, out_max_q}) - $signed({1'b0, out_min_q});
		anum     = prod_q[23] ? 23'(-prod_q[23:0]) : prod_q[22:0];
		anum_rnd = {1'b0, anum} + 24'd10;
		y        = 22'(anum_rnd >> 2);
		q        = prod_q[RECIP_SHIFT+18:RECIP_SHIFT];
		mapped   = (num_neg_q ? -$signed({5'b0, q}) : $signed({5'b0, q}))
		         + $signed({8'b0, out_min_q, 8'b0});

		isum = 34'(integral_q) + $signed({{2{mapped_q[23]}}, mapped_q, 8'b0});
		lim  = $signed({3'b0, integral_limit_q});
		if (isum > lim) begin
			isum_c = 32'(lim);
		end else if (isum < -lim) begin
			isum_c = 32'(-lim);
		end else begin
			isum_c = 32'(isum);
		end

		// Proportional clamp: the upper bound is tested first.
		p16 = prod_q[40:0];
		if (p16 >= $signed({17'b0, out_max_q, 16'b0})) begin
			p16_c = {out_max_q, 16'b0};
		end else if (p16 <= $signed({17'b0, out_min_q, 16'b0})) begin
			p16_c = {out_min_q, 16'b0};
		end else begin
			p16_c = p16[23:0];
		end

		// In window, round half up to an integer drive, then saturate to 0..pwm_top.
		rnd     = acc_q + ACC_W'(24'h800000);
		drv_raw = rnd[51:24];
		if (!inwin_q) begin
			drive = (pwm_top_q < FULL_DRIVE) ? pwm_top_q : FULL_DRIVE;
		end else if (acc_q[ACC_W-1]) begin
			drive = 16'd0;
		end else if (drv_raw > 28'(pwm_top_q)) begin
			drive = pwm_top_q;
		end else begin
			drive = drv_raw[15:0];
		end
	end

	// Multiplier operand selection per step.
	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		unique case (state_q)
			ST_MNUM: begin
				mul_a = MUL_A_W'(diff);
				mul_b = $signed({6'b0, mag_q});
			end
			ST_MQ: begin
				mul_a = $signed({11'b0, y});
				mul_b = $signed({1'b0, RECIP_FIVE});
			end
			ST_MP: begin
				mul_a = MUL_A_W'(mapped_q);
				mul_b = $signed({5'b0, prop_gain_q});
			end
			ST_CLP: begin
				mul_a = MUL_A_W'(integral_q);
				mul_b = $signed({5'b0, int_gain_dt_q});
			end
			ST_MD: begin
				mul_a = MUL_A_W'(deriv_q);
				mul_b = $signed({5'b0, deriv_gain_dt_q});
			end
			ST_IDLE, ST_MAP, ST_ADDD, ST_FIN: begin
				mul_en = 1'b0;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q      <= RST_PROP_GAIN;
			int_gain_dt_q    <= RST_INT_GAIN_DT;
			deriv_gain_dt_q  <= RST_DERIV_GAIN_DT;
			out_min_q        <= RST_OUT_MIN;
			out_max_q        <= RST_OUT_MAX;
			integral_limit_q <= RST_INTEGRAL_LIMIT;
			error_window_q   <= RST_ERROR_WINDOW;
			pwm_top_q        <= RST_PWM_TOP;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PROP_GAIN:      prop_gain_q      <= cfg_data[15:0];
				REG_INT_GAIN_DT:    int_gain_dt_q    <= cfg_data[15:0];
				REG_DERIV_GAIN_DT:  deriv_gain_dt_q  <= cfg_data[15:0];
				REG_OUT_MIN:        out_min_q        <= cfg_data[7:0];
				REG_OUT_MAX:        out_max_q        <= cfg_data[7:0];
				REG_INTEGRAL_LIMIT: integral_limit_q <= cfg_data[30:0];
				REG_ERROR_WINDOW:   error_window_q   <= cfg_data[14:0];
				REG_PWM_TOP:        pwm_top_q        <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer, loop state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			prev_q     <= '0;
			integral_q <= '0;
			m_tvalid   <= 1'b0;
		end else begin
			// A finished result loads the output register as soon as it is free
			// or being taken in this cycle; otherwise a taken result drops valid.
			if (state_q == ST_FIN && (!m_tvalid || m_tready)) begin
				m_tvalid <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= in_win ? ST_MNUM : ST_FIN;
					end
				end
				ST_MNUM: state_q <= ST_MQ;
				ST_MQ:   state_q <= ST_MAP;
				ST_MAP:  state_q <= ST_MP;
				ST_MP: begin
					prev_q     <= mapped_q;
					integral_q <= isum_c;
					state_q    <= ST_CLP;
				end
				ST_CLP:  state_q <= ST_MD;
				ST_MD:   state_q <= ST_ADDD;
				ST_ADDD: state_q <= ST_FIN;
				ST_FIN: begin
					if (!m_tvalid || m_tready) begin
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working registers without reset.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				mag_q   <= mag_ext[14:0];
				inwin_q <= in_win;
			end
			ST_MQ: begin
				num_neg_q <= prod_q[23];
			end
			ST_MAP: begin
				mapped_q <= mapped;
			end
			ST_MP: begin
				deriv_q <= 25'(mapped_q) - 25'(prev_q);
			end
			ST_CLP: begin
				acc_q <= $signed({20'b0, p16_c, 8'b0});
			end
			ST_MD: begin
				acc_q <= acc_q + prod_q[ACC_W-1:0];
			end
			ST_ADDD: begin
				acc_q <= acc_q + $signed({prod_q[43:0], 8'b0});
			end
			ST_FIN: begin
				if (!m_tvalid || m_tready) begin
					m_tdata <= {drive, pwm_top_q - drive};
					m_tuser <= inwin_q;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	// An accepted request keeps the input side closed on the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted again while a sample is in work");

	// A presented result is consistent with the PWM top value.
	a_compare_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[31:16] <= pwm_top_q) &&
		(m_tdata[15:0] == 16'(pwm_top_q - m_tdata[31:16])))
		else $error("compare value and drive level disagree with pwm top");

	// Out-of-window results never exceed full drive.
	a_full_drive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[31:16] <= FULL_DRIVE)
		else $error("out-of-window drive above full drive");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_pid_pwm_drive_unit.sv =====
// ----------------------------------------------------------------------------
// tb_pid_pwm_drive_unit
// Self-checking bench for the PID PWM drive unit. A cycle-free predictor keeps
// its own register copy, previous mapped error and integral, and works out the
// compare value, drive level and window flag of every accepted error sample.
// Directed corners come first, then random register settings with mostly
// in-window errors, random idling on both streams and a long output stall.
// ----------------------------------------------------------------------------

module tb_pid_pwm_drive_unit;
	import ppd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ERR_W        = ERROR_WIDTH_DEF;
	localparam int ERR_BYTES_W  = ((ERR_W + 7) / 8) * 8;
	localparam int STALL_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 250;
	localparam int PHASE_ITEMS  = 120;
	localparam int PHASE_COUNT  = 8;
	localparam int IDLE_PERCENT = 12;
	localparam int PRINT_CAP    = 200;

	typedef struct {
		logic [15:0] prop_gain;
		logic [15:0] int_gain_dt;
		logic [15:0] deriv_gain_dt;
		logic [7:0]  out_min;
		logic [7:0]  out_max;
		logic [30:0] integral_limit;
		logic [14:0] error_window;
		logic [15:0] pwm_top;
	} drive_cfg_t;

	typedef struct {
		logic [15:0] compare_value;
		logic [15:0] drive_level;
		logic        in_window;
	} drive_result_t;

	logic                    clk;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [ERR_BYTES_W-1:0]  s_tdata;
	logic                    m_tvalid;
	logic                    m_tready;
	logic [31:0]             m_tdata;
	logic                    m_tuser;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;

	// Predictor state: register copy, previous mapped error (Q.8) and
	// integral (Q16.16), all kept wide enough to hold every reachable value.
	drive_cfg_t    cfg_shadow;
	longint        last_mapped;
	longint        integ_acc;
	drive_result_t drive_expect_q[$];

	int  err_count;
	int  quiet_cycles;
	int  rx_hold_left;
	bit  rx_idle_en;
	bit  tx_idle_en;

	pid_pwm_drive_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic drive_cfg_t default_config();
		drive_cfg_t c;
		c.prop_gain      = RST_PROP_GAIN;
		c.int_gain_dt    = RST_INT_GAIN_DT;
		c.deriv_gain_dt  = RST_DERIV_GAIN_DT;
		c.out_min        = RST_OUT_MIN;
		c.out_max        = RST_OUT_MAX;
		c.integral_limit = RST_INTEGRAL_LIMIT;
		c.error_window   = RST_ERROR_WINDOW;
		c.pwm_top        = RST_PWM_TOP;
		return c;
	endfunction

	// Works out the result of one error sample and advances the loop state.
	function automatic drive_result_t predict_drive(input logic [ERR_W-1:0] raw);
		drive_result_t r;
		longint err, mag, num, quo, mapped, p16, lim, isum, total, drive, top;
		err = longint'($signed(raw));
		mag = (err < 0) ? -err : err;
		top = longint'(cfg_shadow.pwm_top);
		if (mag < longint'(cfg_shadow.error_window)) begin
			num = (longint'(cfg_shadow.out_max) - longint'(cfg_shadow.out_min)) * mag;
			// Divide by twenty, rounding to nearest with ties away from zero.
			quo = ((num < 0 ? -num : num) + 10) / 20;
			mapped = (num < 0 ? -quo : quo) + longint'(cfg_shadow.out_min) * 256;
			// The upper bound is tested first, so with swapped min/max it wins where both hold.
			p16 = longint'(cfg_shadow.prop_gain) * mapped;
			if (p16 >= longint'(cfg_shadow.out_max) * 65536)
				p16 = longint'(cfg_shadow.out_max) * 65536;
			else if (p16 <= longint'(cfg_shadow.out_min) * 65536)
				p16 = longint'(cfg_shadow.out_min) * 65536;
			lim = longint'(cfg_shadow.integral_limit);
			isum = integ_acc + mapped * 256;
			if (isum > lim)
				isum = lim;
			else if (isum < -lim)
				isum = -lim;
			total = p16 * 256
				+ longint'(cfg_shadow.int_gain_dt) * isum
				+ longint'(cfg_shadow.deriv_gain_dt) * (mapped - last_mapped) * 256;
			last_mapped = mapped;
			integ_acc = isum;
			drive = (total < 0) ? 0 : ((total + (longint'(1) << 23)) >>> 24);
			r.in_window = 1'b1;
		end else begin
			// Outside the window the loop state is left alone.
			drive = longint'(FULL_DRIVE);
			r.in_window = 1'b0;
		end
		if (drive > top)
			drive = top;
		r.drive_level = drive[15:0];
		r.compare_value = 16'(top - drive);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (err_count < PRINT_CAP)
			$display("%0t ns: %s mismatch, got %0d, expected %0d", $realtime, what, got, want);
		err_count++;
	endtask

	// Writes one register and keeps valid up; apply_config lowers it.
	// Bits above the register width carry junk the block must drop.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] field,
			input int width);
		logic [CFG_DATA_W-1:0] data;
		data = (width >= CFG_DATA_W) ? field : ((32'($urandom()) << width) | field);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_PROP_GAIN:      cfg_shadow.prop_gain = data[15:0];
			REG_INT_GAIN_DT:    cfg_shadow.int_gain_dt = data[15:0];
			REG_DERIV_GAIN_DT:  cfg_shadow.deriv_gain_dt = data[15:0];
			REG_OUT_MIN:        cfg_shadow.out_min = data[7:0];
			REG_OUT_MAX:        cfg_shadow.out_max = data[7:0];
			REG_INTEGRAL_LIMIT: cfg_shadow.integral_limit = data[30:0];
			REG_ERROR_WINDOW:   cfg_shadow.error_window = data[14:0];
			REG_PWM_TOP:        cfg_shadow.pwm_top = data[15:0];
			default: ;
		endcase
	endtask

	// Only called with the block idle. A write to an unmapped index goes first
	// and must leave every register untouched.
	task automatic apply_config(input drive_cfg_t c);
		write_reg(CFG_IDX_W'($urandom_range(int'(REG_PWM_TOP) + 1, 255)), $urandom(), 32);
		write_reg(REG_PROP_GAIN, c.prop_gain, 16);
		write_reg(REG_INT_GAIN_DT, c.int_gain_dt, 16);
		write_reg(REG_DERIV_GAIN_DT, c.deriv_gain_dt, 16);
		write_reg(REG_OUT_MIN, c.out_min, 8);
		write_reg(REG_OUT_MAX, c.out_max, 8);
		write_reg(REG_INTEGRAL_LIMIT, c.integral_limit, 31);
		write_reg(REG_ERROR_WINDOW, c.error_window, 15);
		write_reg(REG_PWM_TOP, c.pwm_top, 16);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_field(input int width, input logic [31:0] rst_val);
		logic [31:0] all_ones;
		all_ones = (32'd1 << width) - 32'd1;
		case ($urandom_range(0, 9))
			0:       return 32'd0;
			1:       return all_ones;
			2:       return rst_val;
			3, 4, 5: return 32'($urandom_range(0, 1023)) & all_ones;
			default: return $urandom() & all_ones;
		endcase
	endfunction

	function automatic drive_cfg_t random_config();
		drive_cfg_t c;
		c.prop_gain      = 16'(pick_field(16, 32'(RST_PROP_GAIN)));
		c.int_gain_dt    = 16'(pick_field(16, 32'(RST_INT_GAIN_DT)));
		c.deriv_gain_dt  = 16'(pick_field(16, 32'(RST_DERIV_GAIN_DT)));
		c.out_min        = 8'(pick_field(8, 32'(RST_OUT_MIN)));
		c.out_max        = 8'(pick_field(8, 32'(RST_OUT_MAX)));
		c.integral_limit = 31'(pick_field(31, 32'(RST_INTEGRAL_LIMIT)));
		c.error_window   = 15'(pick_field(15, 32'(RST_ERROR_WINDOW)));
		c.pwm_top        = 16'(pick_field(16, 32'(RST_PWM_TOP)));
		return c;
	endfunction

	// Mostly in-window errors of either sign, some right on the window edge,
	// the rest raw 16-bit noise.
	function automatic logic [ERR_W-1:0] pick_error();
		int mag;
		int roll;
		roll = $urandom_range(0, 99);
		if (cfg_shadow.error_window == 0 || roll >= 80)
			return ERR_W'($urandom());
		if (roll < 5)
			mag = int'(cfg_shadow.error_window) - $urandom_range(0, 1);
		else
			mag = $urandom_range(0, int'(cfg_shadow.error_window) - 1);
		return $urandom_range(0, 1) ? ERR_W'(-mag) : ERR_W'(mag);
	endfunction

	// Offers one error sample and returns in the step it is accepted, with
	// valid still high so a following sample can go back to back.
	task automatic send_error(input logic [ERR_W-1:0] err);
		if (tx_idle_en && $urandom_range(0, 99) < IDLE_PERCENT) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5))
				@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= ERR_BYTES_W'(err);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		drive_expect_q.push_back(predict_drive(err));
	endtask

	task automatic stop_sending();
		s_tvalid <= 1'b0;
	endtask

	// Sampled on the falling edge, after the checker has had its say.
	task automatic wait_results_drained();
		while (drive_expect_q.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++)
			send_error(pick_error());
		stop_sending();
		wait_results_drained();
	endtask

	// Window edges and field extremes with the register values out of reset.
	task automatic test_reset_defaults();
		send_error(16'h0000);
		send_error(16'h0001);
		send_error(16'hFFFF);
		send_error(16'd2303);
		send_error(-16'sd2303);
		send_error(16'd2304);
		send_error(-16'sd2304);
		send_error(16'h7FFF);
		send_error(16'h8000);
		send_error(16'd1500);
		stop_sending();
		wait_results_drained();
	endtask

	task automatic test_config_corners();
		drive_cfg_t c;

		// Everything at zero: no gain, no range, no PWM period.
		c = '{default: '0};
		apply_config(c);
		send_error(16'd100);
		send_error(16'h8000);
		stop_sending();
		wait_results_drained();

		// Everything at its top value, but out_min at zero.
		c.prop_gain = '1;
		c.int_gain_dt = '1;
		c.deriv_gain_dt = '1;
		c.out_min = '0;
		c.out_max = '1;
		c.integral_limit = '1;
		c.error_window = '1;
		c.pwm_top = '1;
		apply_config(c);
		send_error(16'd32766);
		send_error(-16'sd32767);
		stop_sending();
		wait_results_drained();

		// Swapped bounds give a negative slope; large errors drive the mapped
		// value and the integral below zero, so the drive bottoms out.
		c = default_config();
		c.out_min = 8'd255;
		c.out_max = 8'd0;
		c.integral_limit = '1;
		c.error_window = '1;
		c.pwm_top = '1;
		apply_config(c);
		send_error(16'd30000);
		send_error(-16'sd30000);
		stop_sending();
		wait_results_drained();

		// A short PWM period, so the drive clips at the top.
		c = default_config();
		c.pwm_top = 16'd10;
		apply_config(c);
		send_error(16'd1000);
		send_error(16'd0);
		stop_sending();
		wait_results_drained();

		// Empty window: every sample is full drive, clipped by the period.
		c = default_config();
		c.error_window = '0;
		c.pwm_top = 16'd100;
		apply_config(c);
		send_error(16'd0);
		stop_sending();
		wait_results_drained();

		// No integral allowed at all.
		c = default_config();
		c.integral_limit = '0;
		c.prop_gain = 16'd256;
		apply_config(c);
		send_error(16'd500);
		send_error(-16'sd500);
		stop_sending();
		wait_results_drained();
	endtask

	// Random register settings, one of them out of reset, one phase free of
	// any idling on either side.
	task automatic test_random_sweep();
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			apply_config((ph == 0) ? default_config() : random_config());
			rx_idle_en = (ph != 3);
			tx_idle_en = (ph != 3);
			send_random(PHASE_ITEMS);
		end
		rx_idle_en = 1'b1;
		tx_idle_en = 1'b1;
	endtask

	// The receiver holds off for a long stretch while samples keep coming, so
	// the result register fills and the input stalls; then the sender waits
	// for every result before going on.
	task automatic test_backpressure();
		apply_config(random_config());
		rx_hold_left = HOLD_CYCLES;
		send_random(40);
		send_random(40);
	endtask

	// Receiver side: random stalls plus the long hold-off, counted here.
	always @(posedge clk) begin
		if (rx_hold_left > 0) begin
			m_tready <= 1'b0;
			rx_hold_left--;
		end else begin
			m_tready <= !(rx_idle_en && $urandom_range(0, 99) < IDLE_PERCENT);
		end
	end

	// Result checker: each result against the oldest outstanding prediction.
	always @(posedge clk) begin
		drive_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (drive_expect_q.size() == 0) begin
				report_mismatch("unexpected result, drive_level", m_tdata[31:16], -1);
			end else begin
				want = drive_expect_q.pop_front();
				if (m_tdata[15:0] !== want.compare_value)
					report_mismatch("compare_value", m_tdata[15:0], want.compare_value);
				if (m_tdata[31:16] !== want.drive_level)
					report_mismatch("drive_level", m_tdata[31:16], want.drive_level);
				if (m_tuser !== want.in_window)
					report_mismatch("in_window", m_tuser, want.in_window);
			end
		end
	end

	// Ends the run once no request has moved on any channel for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[pid_pwm_drive_unit] ERROR");
			$finish;
		end
	end

	initial begin
		err_count = 0;
		quiet_cycles = 0;
		rx_hold_left = 0;
		rx_idle_en = 1'b1;
		tx_idle_en = 1'b1;
		cfg_shadow = default_config();
		last_mapped = 0;
		integ_acc = 0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		m_tready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_config_corners();
		test_random_sweep();
		test_backpressure();

		wait_results_drained();
		repeat (12)
			@(posedge clk);
		if (err_count == 0)
			$display("[pid_pwm_drive_unit] OK");
		else
			$display("[pid_pwm_drive_unit] ERROR");
		$finish;
	end

endmodule
